// File: rtl/core/awss_pkg.sv
// Shared types and constants for the waveshaping saturator.
// Holds the CORDIC word format, the angle table and register indexes.
// No dependencies.
package awss_pkg;

  localparam int unsigned CW = 38;  // CORDIC datapath width, Q.30

  localparam logic signed [CW-1:0] Q30_ONE      = 38'sd1073741824;
  localparam logic signed [CW-1:0] Q30_ONE_K    = 38'sd652032874;
  localparam logic signed [CW-1:0] Q30_PI       = 38'sd3373259426;
  localparam logic signed [CW-1:0] Q30_HALF_PI  = 38'sd1686629713;
  localparam logic signed [CW-1:0] Q30_TWO_PI   = 38'sd6746518852;
  localparam logic signed [CW-1:0] Q30_FOUR_PI  = 38'sd13493037704;

  localparam logic signed [34:0] OUT_LIMIT = 35'sd83886080;

  localparam logic [1:0] REG_DRIVE_GAIN = 2'd0;
  localparam logic [1:0] REG_SHAPE_MODE = 2'd1;
  localparam logic [1:0] REG_WET_MIX    = 2'd2;

  localparam logic [2:0] MODE_ATAN    = 3'd0;
  localparam logic [2:0] MODE_SINE    = 3'd1;
  localparam logic [2:0] MODE_RECTIFY = 3'd2;
  localparam logic [2:0] MODE_QUARTER = 3'd3;

  // Values that ride alongside the rotation unchanged.
  typedef struct packed {
    logic [2:0]         mode;
    logic signed [23:0] s;
    logic [16:0]        w;
    logic signed [31:0] alt;
  } side_t;

  typedef struct packed {
    logic                  valid;
    logic                  vec;   // 1: vectoring (arctan), 0: rotation (sine)
    logic signed [CW-1:0]  cx;
    logic signed [CW-1:0]  cy;
    logic signed [CW-1:0]  z;
    side_t                 side;
  } cordic_t;

  // atan(2^-i) in Q.30, truncated.
  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] r;
    unique case (i)
      0:  r = 38'sh03243F6A8;
      1:  r = 38'sh01DAC6705;
      2:  r = 38'sh00FADBAFC;
      3:  r = 38'sh007F56EA6;
      4:  r = 38'sh003FEAB76;
      5:  r = 38'sh001FFD55B;
      6:  r = 38'sh000FFFAAA;
      7:  r = 38'sh0007FFF55;
      8:  r = 38'sh0003FFFEA;
      9:  r = 38'sh0001FFFFD;
      10: r = 38'sh0000FFFFF;
      11: r = 38'sh00007FFFF;
      12: r = 38'sh00003FFFF;
      13: r = 38'sh00001FFFF;
      14: r = 38'sh00000FFFF;
      15: r = 38'sh000007FFF;
      16: r = 38'sh000003FFF;
      17: r = 38'sh000001FFF;
      18: r = 38'sh000000FFF;
      19: r = 38'sh0000007FF;
      20: r = 38'sh0000003FF;
      21: r = 38'sh0000001FF;
      22: r = 38'sh0000000FF;
      23: r = 38'sh00000007F;
      24: r = 38'sh00000003F;
      25: r = 38'sh00000001F;
      26: r = 38'sh00000000F;
      27: r = 38'sh000000008;
      28: r = 38'sh000000004;
      29: r = 38'sh000000002;
      30: r = 38'sh000000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/awss_cordic_cell.sv
// One CORDIC micro-rotation with its output register.
// Depends on awss_pkg for the word format and the angle table.
module awss_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  awss_pkg::cordic_t din,
  output awss_pkg::cordic_t dout
);
  import awss_pkg::*;

  localparam logic signed [CW-1:0] ANGLE = atan_q30(STAGE);

  logic signed [CW-1:0] dx, dy;
  logic                 up;
  cordic_t              dout_next;

  // Arithmetic shift gives the floor of the scaled neighbor.
  assign dx = din.cy >>> STAGE;
  assign dy = din.cx >>> STAGE;
  // Vectoring drives y to zero; rotation drives the residual angle to zero.
  assign up = din.vec ? din.cy[CW-1] : ~din.z[CW-1];

  always_comb begin
    dout_next = din;
    if (up) begin
      dout_next.cx = din.cx - dx;
      dout_next.cy = din.cy + dy;
      dout_next.z  = din.z - ANGLE;
    end else begin
      dout_next.cx = din.cx + dx;
      dout_next.cy = din.cy - dy;
      dout_next.z  = din.z + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    dout <= dout_next;
    if (rst) begin
      dout.valid <= 1'b0;
    end
  end

endmodule

// File: rtl/core/audio_waveshaper_saturation_top.sv
// Top level of the waveshaping saturator with dry/wet mix.
// Depends on awss_pkg and instantiates a row of awss_cordic_cell.
//
//   channel   signals                               direction  word
//   input     start, busy, sample_in                in         one Q1.23 sample
//   result    done, sample_out                      out        one mixed sample
//   config    cfg_valid, cfg_ready, cfg_index,      in         one register write
//             cfg_data
//
// A new sample is taken in every clock cycle; busy is always low. The gain
// product is registered at the edge that takes the sample; the result then
// passes the rounding, range reduction, setup, CORDIC cell row, mixing product
// and sum/clamp registers before it is on the ports. The result is shown for
// one cycle with done high; the receiver cannot hold it off. Synchronous
// reset empties the pipeline and loads the register defaults: gain 1.0,
// arctan, fully wet.
module audio_waveshaper_saturation_top #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] sample_in,
  output logic               done,
  output logic signed [27:0] sample_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data
);
  import awss_pkg::*;

  // Configuration registers.
  logic [15:0] drive_gain;
  logic [2:0]  shape_mode;
  logic [16:0] wet_mix;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_gain <= 16'd4096;
      shape_mode <= MODE_ATAN;
      wet_mix    <= 17'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DRIVE_GAIN: drive_gain <= cfg_data[15:0];
        REG_SHAPE_MODE: shape_mode <= cfg_data[2:0];
        REG_WET_MIX:    wet_mix    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: gain product. Register settings are captured with the sample.
  logic               v1;
  logic signed [40:0] prod1;
  side_t              sd1;

  always_ff @(posedge clk) begin
    prod1       <= sample_in * $signed({1'b0, drive_gain});
    sd1.s       <= sample_in;
    sd1.mode    <= shape_mode;
    sd1.w       <= (wet_mix > 17'd65536) ? 17'd65536 : wet_mix;
    sd1.alt     <= '0;
    v1          <= start && !busy;
    if (rst) begin
      v1 <= 1'b0;
    end
  end

  // Stage 2: round the product to the Q.23 drive value x.
  logic               v2;
  logic signed [28:0] x2;
  logic signed [40:0] prod_rnd;
  side_t              sd2;

  assign prod_rnd = prod1 + 41'sd2048;

  always_ff @(posedge clk) begin
    x2  <= prod_rnd[40:12];
    sd2 <= sd1;
    v2  <= v1;
    if (rst) begin
      v2 <= 1'b0;
    end
  end

  // Stage 3: x in Q.30 modulo two pi, truncating toward zero. |x| stays
  // below three turns, so at most two turns come off.
  logic               v3;
  logic signed [28:0] x3;
  logic signed [CW-1:0] a3;
  side_t              sd3;
  logic signed [CW-1:0] v30, mag, rem;

  always_comb begin
    v30 = CW'(x2) <<< 7;
    mag = v30[CW-1] ? -v30 : v30;
    if (mag >= Q30_FOUR_PI) begin
      rem = mag - Q30_FOUR_PI;
    end else if (mag >= Q30_TWO_PI) begin
      rem = mag - Q30_TWO_PI;
    end else begin
      rem = mag;
    end
  end

  always_ff @(posedge clk) begin
    a3  <= v30[CW-1] ? -rem : rem;
    x3  <= x2;
    sd3 <= sd2;
    v3  <= v2;
    if (rst) begin
      v3 <= 1'b0;
    end
  end

  // Stage 4: wrap into [-pi, pi], fold into [-pi/2, pi/2], build the simple
  // shapes, and load the CORDIC start vector.
  logic signed [CW-1:0] wrap, fold;
  logic signed [29:0]   xs, xabs;
  logic [29:0]          qm;
  logic signed [31:0]   alt4;
  cordic_t              chain [CORDIC_STAGES+1];
  cordic_t              init_next;

  always_comb begin
    if (a3 > Q30_PI) begin
      wrap = a3 - Q30_TWO_PI;
    end else if (a3 < -Q30_PI) begin
      wrap = a3 + Q30_TWO_PI;
    end else begin
      wrap = a3;
    end
    if (wrap > Q30_HALF_PI) begin
      fold = Q30_PI - wrap;
    end else if (wrap < -Q30_HALF_PI) begin
      fold = -Q30_PI - wrap;
    end else begin
      fold = wrap;
    end

    xs   = 30'(x3);
    xabs = xs[29] ? -xs : xs;
    // Nearest quarter, ties away from zero, on the magnitude.
    qm   = ((30'(xabs) + 30'd1048576) >> 21) << 21;
    if (sd3.mode == MODE_QUARTER) begin
      alt4 = xs[29] ? -32'(signed'(qm)) : 32'(signed'(qm));
    end else begin
      alt4 = 32'(xabs);
    end

    init_next          = '0;
    init_next.valid    = v3;
    init_next.side     = sd3;
    init_next.side.alt = alt4;
    if (sd3.mode == MODE_SINE) begin
      init_next.vec = 1'b0;
      init_next.cx  = Q30_ONE_K;
      init_next.cy  = '0;
      init_next.z   = fold;
    end else begin
      init_next.vec = 1'b1;
      init_next.cx  = Q30_ONE;
      init_next.cy  = CW'(x3) <<< 7;
      init_next.z   = '0;
    end
  end

  always_ff @(posedge clk) begin
    chain[0] <= init_next;
    if (rst) begin
      chain[0].valid <= 1'b0;
    end
  end

  // The row of CORDIC cells, one micro-rotation per cycle.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    awss_cordic_cell #(.STAGE(i)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // Stage 5: pick the shaped value and form both mix products.
  cordic_t              co;
  logic signed [CW-1:0] z_rnd, y_rnd;
  logic signed [31:0]   shaped;
  logic                 v5;
  logic signed [49:0]   p_wet;
  logic signed [41:0]   p_dry;

  assign co    = chain[CORDIC_STAGES];
  assign z_rnd = (co.z + 38'sd64) >>> 7;
  assign y_rnd = (co.cy + 38'sd64) >>> 7;

  always_comb begin
    unique case (co.side.mode)
      MODE_ATAN:    shaped = z_rnd[31:0];
      MODE_SINE:    shaped = y_rnd[31:0];
      MODE_RECTIFY: shaped = co.side.alt;
      MODE_QUARTER: shaped = co.side.alt;
      default:      shaped = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    p_wet <= $signed({1'b0, co.side.w}) * shaped;
    p_dry <= $signed({1'b0, 17'(17'd65536 - co.side.w)}) * co.side.s;
    v5    <= co.valid;
    if (rst) begin
      v5 <= 1'b0;
    end
  end

  // Stage 6: sum, round to Q.23 and clamp to plus or minus 10.0.
  logic signed [50:0] sum;
  logic signed [34:0] mix;
  logic signed [34:0] clamped;

  always_comb begin
    sum = 51'(p_wet) + 51'(p_dry) + 51'sd32768;
    mix = sum[50:16];
    if (mix > OUT_LIMIT) begin
      clamped = OUT_LIMIT;
    end else if (mix < -OUT_LIMIT) begin
      clamped = -OUT_LIMIT;
    end else begin
      clamped = mix;
    end
  end

  always_ff @(posedge clk) begin
    sample_out <= clamped[27:0];
    done       <= v5;
    if (rst) begin
      done <= 1'b0;
    end
  end

endmodule

// File: dv/awss_checker.sv
// Checker for the waveshaping saturator: watches the config, input and result channels.
// Predicts each mixed sample from its own copy of the registers and compares.
// Depends on awss_pkg.
module awss_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [23:0] sample_in,
  input  logic               done,
  input  logic signed [27:0] sample_out,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  import awss_pkg::*;

  localparam int STAGES = 24;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;
  localparam longint GAIN_K_Q30 = 64'sd652032874;
  localparam longint SAT_LIMIT = 64'sd83886080;

  // Arctangent of 2^-i in Q.30, truncated.
  localparam longint ANGLE_TBL[24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

  logic [15:0] gain_q;
  logic [2:0]  mode_q;
  logic [16:0] wet_q;
  logic signed [27:0] mixed_q[$];

  function automatic longint rotate_atan(longint x);
    longint cx, cy, z, dx, dy;
    cx = 64'sd1 <<< 30;
    cy = x * 128;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += ANGLE_TBL[i];
      end else begin
        cx -= dx; cy += dy; z -= ANGLE_TBL[i];
      end
    end
    return (z + 64) >>> 7;
  endfunction

  function automatic longint rotate_sine(longint x);
    longint a, cx, cy, dx, dy;
    a = (x * 128) % TWO_PI_Q30;
    cx = GAIN_K_Q30;
    cy = 0;
    if (a > PI_Q30) a -= TWO_PI_Q30;
    if (a < -PI_Q30) a += TWO_PI_Q30;
    if (a > HALF_PI_Q30) a = PI_Q30 - a;
    if (a < -HALF_PI_Q30) a = -PI_Q30 - a;
    for (int i = 0; i < STAGES; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (a >= 0) begin
        cx -= dx; cy += dy; a -= ANGLE_TBL[i];
      end else begin
        cx += dx; cy -= dy; a += ANGLE_TBL[i];
      end
    end
    return (cy + 64) >>> 7;
  endfunction

  function automatic logic signed [27:0] mix_sample(logic signed [23:0] s_in);
    longint s, x, shaped, w, m, mag;
    s = s_in;
    x = (s * longint'(gain_q) + 2048) >>> 12;
    case (mode_q)
      MODE_ATAN:    shaped = rotate_atan(x);
      MODE_SINE:    shaped = rotate_sine(x);
      MODE_RECTIFY: shaped = x < 0 ? -x : x;
      MODE_QUARTER: begin
        mag = x < 0 ? -x : x;
        mag = ((mag + (64'sd1 <<< 20)) / (64'sd1 <<< 21)) * (64'sd1 <<< 21);
        shaped = x < 0 ? -mag : mag;
      end
      default:      shaped = 0;
    endcase
    w = wet_q > 17'd65536 ? 65536 : longint'(wet_q);
    m = (w * shaped + (65536 - w) * s + 32768) >>> 16;
    if (m > SAT_LIMIT) m = SAT_LIMIT;
    if (m < -SAT_LIMIT) m = -SAT_LIMIT;
    return m[27:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      gain_q <= 16'd4096;
      mode_q <= MODE_ATAN;
      wet_q  <= 17'd65536;
      mixed_q.delete();
      errors  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DRIVE_GAIN: gain_q <= cfg_data[15:0];
          REG_SHAPE_MODE: mode_q <= cfg_data[2:0];
          REG_WET_MIX:    wet_q  <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) mixed_q.push_back(mix_sample(sample_in));
      if (done) begin
        if (mixed_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: got %0d", sample_out);
        end else if (mixed_q[0] !== sample_out) begin
          errors++;
          if (errors <= 10)
            $display("word mismatch: expected %0d got %0d", mixed_q[0], sample_out);
          void'(mixed_q.pop_front());
        end else begin
          void'(mixed_q.pop_front());
        end
      end
    end
    pending = mixed_q.size();
  end
endmodule

// File: dv/tb_top.sv
// Testbench top for the waveshaping saturator: clock, reset, stimulus and verdict.
// Depends on awss_pkg, audio_waveshaper_saturation_top and awss_checker.
module tb_top;
  import awss_pkg::*;

  // Index three addresses no register; writes to it must change nothing.
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [23:0] sample_in = '0;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;
  logic busy, done, cfg_ready;
  logic signed [27:0] sample_out;
  int errors, pending;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  audio_waveshaper_saturation_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample_in(sample_in),
    .done(done), .sample_out(sample_out), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  awss_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample_in(sample_in),
    .done(done), .sample_out(sample_out), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // Offer one sample word. Start stays high between back-to-back words so it is
  // never lowered and raised in the same step; an idle cycle lowers it first.
  task automatic send_sample(logic signed [23:0] v, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    sample_in <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Registers change only with the pipeline empty: wait out every expected
  // word, then wait a further DRAIN_CYCLES before the write.
  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly full-range samples, with some near zero and some on quarter-step
  // ties, where rounding away from zero matters.
  function automatic logic signed [23:0] pick_sample();
    int k;
    k = $urandom_range(9);
    if (k < 6) return 24'($urandom);
    if (k < 8) return $signed(24'($urandom_range(2047))) - 24'sd1024;
    return $signed(24'($urandom_range(15))) * 24'sd1048576 - 24'sd8388608
           + $signed(24'($urandom_range(2)) - 24'sd1);
  endfunction

  function automatic logic [16:0] pick_gain();
    case ($urandom_range(5))
      0: return 17'd4096;
      1: return 17'd40960;
      2: return 17'd0;
      3: return 17'hFFFF;
      default: return 17'($urandom_range(40960, 4096));
    endcase
  endfunction

  function automatic logic [16:0] pick_wet();
    case ($urandom_range(5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF;
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  initial begin
    #400000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int idle;
    logic signed [23:0] edge_words[3];
    edge_words = '{24'sh800000, 24'sh7FFFFF, 24'sh300000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: full-scale words and a quarter-step word in every mode at a
    // gain of 10.0, which takes the output to the clamp limit.
    write_reg(REG_DRIVE_GAIN, 17'd40960);
    write_reg(REG_NONE, 17'h1FFFF);
    for (int m = 0; m < 8; m++) begin
      write_reg(REG_SHAPE_MODE, 17'(m));
      for (int j = 0; j < 3; j++) send_sample(edge_words[j], 0);
    end

    // Random: each segment picks a fresh setting. Sender idling runs at 8%,
    // then 56%, then not at all, over thirds of the run.
    for (int seg = 0; seg < 24; seg++) begin
      idle = seg < 8 ? 8 : (seg < 16 ? 56 : 0);
      write_reg(REG_DRIVE_GAIN, pick_gain());
      write_reg(REG_SHAPE_MODE, 17'($urandom));
      write_reg(REG_WET_MIX, pick_wet());
      if ($urandom_range(3) == 0) write_reg(REG_NONE, 17'($urandom));
      for (int n = 0; n < 80; n++) send_sample(pick_sample(), idle);
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/core/awss_pkg.sv
rtl/core/awss_cordic_cell.sv
rtl/core/audio_waveshaper_saturation_top.sv
dv/awss_checker.sv
dv/tb_top.sv
